>>> design/tawc_pkg.sv
package tawc_pkg;

   // item opcodes
   localparam logic [1:0] OP_NEW_ACK = 2'd0;
   localparam logic [1:0] OP_DUP_ACK = 2'd1;
   localparam logic [1:0] OP_TIMEOUT = 2'd2;

   // retransmit kinds
   localparam logic [1:0] RX_NONE    = 2'd0;
   localparam logic [1:0] RX_FAST    = 2'd1;
   localparam logic [1:0] RX_TIMEOUT = 2'd2;

   // send kinds
   localparam logic [1:0] SEND_NONE     = 2'd0;
   localparam logic [1:0] SEND_NORMAL   = 2'd1;
   localparam logic [1:0] SEND_RECOVERY = 2'd2;

   // register indexes
   localparam int unsigned CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_SEG_SIZE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INCR_FACTOR = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DUP_LIMIT   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOW_THRESH = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SACK_ON     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_WINDOW = 3'd5;

   // register reset values
   localparam logic [15:0] SEG_SIZE_RESET    = 16'd1460;
   localparam logic [7:0]  INCR_FACTOR_RESET = 8'd1;
   localparam logic [3:0]  DUP_LIMIT_RESET   = 4'd3;
   localparam logic [31:0] SLOW_THRESH_RESET = 32'd65535;
   localparam logic        SACK_ON_RESET     = 1'b1;
   localparam logic [31:0] INIT_WINDOW_RESET = 32'd4380;

   // bytes taken off the segment size in the pipe quotient
   localparam logic [15:0] HDR_BYTES = 16'd12;

   // divider: quotient bits resolved per cycle
   localparam int unsigned DIV_WIDTH     = 32;
   localparam int unsigned DIV_STEP_BITS = 4;

   typedef struct packed {
      logic [15:0] seg_size;
      logic [7:0]  incr_factor;
      logic [3:0]  dup_limit;
      logic [31:0] slow_thresh;
      logic        sack_on;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [7:0]  dup_count;
      logic [31:0] acked_seq;
      logic [31:0] highest_sent;
      logic [31:0] pipe_bytes;
      logic        abort_flag;
   } item_type;

   typedef struct packed {
      logic [31:0] window;
      logic        in_recovery;
      logic [1:0]  retransmit_kind;
      logic [1:0]  send_kind;
      logic [31:0] lost_segments;
      logic        timeout_seen;
   } result_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_WIDTH-1:0] dividend;
      logic [DIV_WIDTH-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_WIDTH-1:0] quotient;
   } div_rsp_type;

   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
   endfunction

   // serial number compare: a at or after b
   function automatic logic seq_ge(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] diff;
      diff = a - b;
      return ~diff[31];
   endfunction

endpackage

>>> design/tawc_div.sv
module tawc_div (
   input  logic                  clock,
   input  logic                  reset,
   input  tawc_pkg::div_req_type req,
   output tawc_pkg::div_rsp_type rsp
);

   localparam int unsigned W     = tawc_pkg::DIV_WIDTH;
   localparam int unsigned STEPS = tawc_pkg::DIV_WIDTH / tawc_pkg::DIV_STEP_BITS;
   localparam int unsigned CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [W-1:0]     rem_ff;
   logic [W-1:0]     quo_ff;
   logic [W-1:0]     dvs_ff;

   logic [W-1:0]     rem_in;
   logic [W-1:0]     quo_in;
   logic [W:0]       part_v;

   // restoring division, several quotient bits per cycle
   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      part_v = '0;
      for (int k = 0; k < int'(tawc_pkg::DIV_STEP_BITS); k++) begin
         part_v = {rem_in, quo_in[W-1]};
         quo_in = {quo_in[W-2:0], 1'b0};
         if (part_v >= {1'b0, dvs_ff}) begin
            part_v    = part_v - {1'b0, dvs_ff};
            quo_in[0] = 1'b1;
         end
         rem_in = part_v[W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            rem_ff  <= '0;
            quo_ff  <= req.dividend;
            dvs_ff  <= req.divisor;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            quo_ff <= quo_in;
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

>>> design/tawc_seq.sv
module tawc_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  tawc_pkg::cfg_type    cfg,
   input  logic                 item_valid,
   output logic                 item_ready,
   input  tawc_pkg::item_type   item,
   output logic                 res_valid,
   input  logic                 res_ready,
   output tawc_pkg::result_type res
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_UNIT,
      S_CNT_GO,
      S_CNT_WAIT,
      S_RECOV,
      S_WQ_GO,
      S_WQ_WAIT,
      S_PQ_GO,
      S_PQ_WAIT,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;

   tawc_pkg::item_type   item_ff, item_in;
   tawc_pkg::result_type res_ff, res_in;
   logic                 res_valid_ff, res_valid_in;

   logic [31:0] cwnd_ff, cwnd_in;
   logic [31:0] credit_ff, credit_in;
   logic        rec_ff, rec_in;
   logic [31:0] rp_ff, rp_in;
   logic        tflag_ff, tflag_in;
   logic [31:0] lost_ff, lost_in;
   logic [1:0]  rexmit_ff, rexmit_in;
   logic [1:0]  sendk_ff, sendk_in;
   logic [23:0] unit_ff, unit_in;
   logic [31:0] wq_ff, wq_in;

   tawc_pkg::div_req_type div_req;
   tawc_pkg::div_rsp_type div_rsp;

   logic [23:0] unit_prod;
   logic [19:0] dup_extra;
   logic        enter_rec;
   logic [31:0] cnt_val;
   logic [31:0] cr_a;
   logic [31:0] cr_b;
   logic [1:0]  add_segs;
   logic [31:0] seg_add;
   logic        can_load;

   tawc_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign unit_prod = {16'd0, cfg.incr_factor} * {8'd0, cfg.seg_size};
   assign dup_extra = {16'd0, cfg.dup_limit} * {4'd0, cfg.seg_size};
   assign enter_rec = (item_ff.dup_count >= {4'd0, cfg.dup_limit}) && !rec_ff &&
                      ((rp_ff == 32'd0) || tawc_pkg::seq_ge(item_ff.acked_seq, rp_ff));
   assign can_load  = !res_valid_ff || res_ready;

   // credit counter: at most one segment from an old surplus, one from this ack
   always_comb begin
      cnt_val  = (div_rsp.quotient == 32'd0) ? 32'd1 : div_rsp.quotient;
      cr_a     = credit_ff;
      add_segs = 2'd0;
      if (cr_a >= cnt_val) begin
         cr_a     = 32'd0;
         add_segs = 2'd1;
      end
      cr_b = cr_a + 32'd1;
      if (cr_b >= cnt_val) begin
         cr_b     = 32'd0;
         add_segs = add_segs + 2'd1;
      end
      case (add_segs)
         2'd1:    seg_add = {16'd0, cfg.seg_size};
         2'd2:    seg_add = {15'd0, cfg.seg_size, 1'b0};
         default: seg_add = 32'd0;
      endcase
   end

   always_comb begin
      div_req.start    = 1'b0;
      div_req.dividend = cwnd_ff;
      div_req.divisor  = 32'd1;
      case (state_ff)
         S_CNT_GO: begin
            div_req.start   = 1'b1;
            div_req.divisor = (unit_ff == 24'd0) ? 32'd1 : {8'd0, unit_ff};
         end
         S_WQ_GO: begin
            div_req.start   = 1'b1;
            div_req.divisor = (cfg.seg_size == 16'd0) ? 32'd1 : {16'd0, cfg.seg_size};
         end
         S_PQ_GO: begin
            div_req.start    = 1'b1;
            div_req.dividend = item_ff.pipe_bytes;
            div_req.divisor  = {16'd0, cfg.seg_size - tawc_pkg::HDR_BYTES};
         end
         default: ;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      res_in       = res_ff;
      res_valid_in = res_valid_ff;
      cwnd_in      = cwnd_ff;
      credit_in    = credit_ff;
      rec_in       = rec_ff;
      rp_in        = rp_ff;
      tflag_in     = tflag_ff;
      lost_in      = lost_ff;
      rexmit_in    = rexmit_ff;
      sendk_in     = sendk_ff;
      unit_in      = unit_ff;
      wq_in        = wq_ff;

      if (res_valid_ff && res_ready) begin
         res_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (item_valid) begin
               item_in  = item;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            rexmit_in = tawc_pkg::RX_NONE;
            sendk_in  = tawc_pkg::SEND_NONE;
            case (item_ff.opcode)
               tawc_pkg::OP_NEW_ACK: begin
                  if (cwnd_ff < cfg.slow_thresh) begin
                     cwnd_in  = tawc_pkg::sat_add(cwnd_ff, {16'd0, cfg.seg_size});
                     state_in = S_RECOV;
                  end else begin
                     state_in = S_UNIT;
                  end
               end
               tawc_pkg::OP_DUP_ACK: begin
                  if (enter_rec) begin
                     rp_in     = item_ff.highest_sent;
                     rec_in    = 1'b1;
                     cwnd_in   = tawc_pkg::sat_add(cfg.slow_thresh, {12'd0, dup_extra});
                     rexmit_in = tawc_pkg::RX_FAST;
                  end
                  if (enter_rec || rec_ff) begin
                     lost_in  = lost_ff + 32'd1;
                     state_in = S_WQ_GO;
                  end else begin
                     state_in = S_FINISH;
                  end
               end
               tawc_pkg::OP_TIMEOUT: begin
                  if (!item_ff.abort_flag) begin
                     cwnd_in   = {16'd0, cfg.seg_size};
                     tflag_in  = 1'b1;
                     rexmit_in = tawc_pkg::RX_TIMEOUT;
                  end
                  state_in = S_FINISH;
               end
               default: state_in = S_FINISH;
            endcase
         end
         S_UNIT: begin
            unit_in  = unit_prod;
            state_in = S_CNT_GO;
         end
         S_CNT_GO: state_in = S_CNT_WAIT;
         S_CNT_WAIT: begin
            if (div_rsp.done) begin
               credit_in = cr_b;
               cwnd_in   = tawc_pkg::sat_add(cwnd_ff, seg_add);
               state_in  = S_RECOV;
            end
         end
         S_RECOV: begin
            if (rec_ff && !(cfg.sack_on && tawc_pkg::seq_ge(item_ff.acked_seq, rp_ff))) begin
               state_in = S_WQ_GO;
            end else begin
               rec_in   = 1'b0;
               sendk_in = tawc_pkg::SEND_NORMAL;
               state_in = S_FINISH;
            end
         end
         S_WQ_GO: state_in = S_WQ_WAIT;
         S_WQ_WAIT: begin
            if (div_rsp.done) begin
               wq_in = div_rsp.quotient;
               if (cfg.seg_size > tawc_pkg::HDR_BYTES) begin
                  state_in = S_PQ_GO;
               end else begin
                  // pipe quotient counts as zero
                  if (div_rsp.quotient != 32'd0) begin
                     sendk_in = tawc_pkg::SEND_RECOVERY;
                  end
                  state_in = S_FINISH;
               end
            end
         end
         S_PQ_GO: state_in = S_PQ_WAIT;
         S_PQ_WAIT: begin
            if (div_rsp.done) begin
               if (wq_ff > div_rsp.quotient) begin
                  sendk_in = tawc_pkg::SEND_RECOVERY;
               end
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (can_load) begin
               res_in.window          = cwnd_ff;
               res_in.in_recovery     = rec_ff;
               res_in.retransmit_kind = rexmit_ff;
               res_in.send_kind       = sendk_ff;
               res_in.lost_segments   = lost_ff;
               res_in.timeout_seen    = tflag_ff;
               res_valid_in           = 1'b1;
               state_in               = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         res_valid_ff <= 1'b0;
         cwnd_ff      <= tawc_pkg::INIT_WINDOW_RESET;
         credit_ff    <= 32'd0;
         rec_ff       <= 1'b0;
         rp_ff        <= 32'd0;
         tflag_ff     <= 1'b0;
         lost_ff      <= 32'd0;
      end else begin
         state_ff     <= state_in;
         res_valid_ff <= res_valid_in;
         cwnd_ff      <= cwnd_in;
         credit_ff    <= credit_in;
         rec_ff       <= rec_in;
         rp_ff        <= rp_in;
         tflag_ff     <= tflag_in;
         lost_ff      <= lost_in;
      end
      item_ff   <= item_in;
      res_ff    <= res_in;
      rexmit_ff <= rexmit_in;
      sendk_ff  <= sendk_in;
      unit_ff   <= unit_in;
      wq_ff     <= wq_in;
   end

   assign item_ready = (state_ff == S_IDLE);
   assign res_valid  = res_valid_ff;
   assign res        = res_ff;

endmodule

>>> design/tcp_alpha_window_control_unit.sv
// congestion window engine for a tcp sender, one word in and one word out per event.
// req channel: one event per word (new ack, duplicate ack or retransmit timeout) with
// the sequence state that goes with it. rsp channel: the window, the recovery flag,
// the retransmit and send decisions and the running counters after that event.
// csr channel: register writes by index, always ready, to be issued only while idle.
// a timeout, an unused opcode or a duplicate ack outside recovery goes straight from
// decode to finish; a new ack in slow start outside recovery also passes the recovery
// check. each division runs on the shared divider (4 quotient bits per cycle, 8 steps).
// a new ack at or above the threshold forms alpha*mss in a state of its own and
// divides once for the credit limit, and each send test in recovery divides once or
// twice. the divider is the only arithmetic that iterates.
// one event is worked at a time; req_tready is high only while the sequencer is idle,
// so a new event is accepted only once the last one has finished its work.
// a finished word waits in the output register, and the next event may be accepted
// meanwhile; if rsp_tready stays low, that event finishes its work and then waits.
// reset clears the window to 4380 bytes, the counters and flags to zero, and the
// registers to their defaults; a later write of initial_window does not move the
// live window.
module tcp_alpha_window_control_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // dup_count, acked_seq, highest_sent, pipe_bytes
   input  logic [103:0]                         req_tdata,
   // opcode, abort_flag
   input  logic [2:0]                           req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // window, lost_segments
   output logic [63:0]                          rsp_tdata,
   // in_recovery, retransmit_kind, send_kind, timeout_seen
   output logic [5:0]                           rsp_tuser,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [tawc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [31:0]                          csr_data
);

   tawc_pkg::cfg_type    cfg_ff;
   tawc_pkg::item_type   item;
   tawc_pkg::result_type res;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.seg_size    <= tawc_pkg::SEG_SIZE_RESET;
         cfg_ff.incr_factor <= tawc_pkg::INCR_FACTOR_RESET;
         cfg_ff.dup_limit   <= tawc_pkg::DUP_LIMIT_RESET;
         cfg_ff.slow_thresh <= tawc_pkg::SLOW_THRESH_RESET;
         cfg_ff.sack_on     <= tawc_pkg::SACK_ON_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            tawc_pkg::CSR_SEG_SIZE:    cfg_ff.seg_size    <= csr_data[15:0];
            tawc_pkg::CSR_INCR_FACTOR: cfg_ff.incr_factor <= csr_data[7:0];
            tawc_pkg::CSR_DUP_LIMIT:   cfg_ff.dup_limit   <= csr_data[3:0];
            tawc_pkg::CSR_SLOW_THRESH: cfg_ff.slow_thresh <= csr_data;
            tawc_pkg::CSR_SACK_ON:     cfg_ff.sack_on     <= csr_data[0];
            // initial window only matters at reset
            tawc_pkg::CSR_INIT_WINDOW: ;
            default: ;
         endcase
      end
   end

   assign item.opcode       = req_tuser[1:0];
   assign item.abort_flag   = req_tuser[2];
   assign item.dup_count    = req_tdata[7:0];
   assign item.acked_seq    = req_tdata[39:8];
   assign item.highest_sent = req_tdata[71:40];
   assign item.pipe_bytes   = req_tdata[103:72];

   tawc_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (req_tvalid),
      .item_ready (req_tready),
      .item       (item),
      .res_valid  (rsp_tvalid),
      .res_ready  (rsp_tready),
      .res        (res)
   );

   assign rsp_tdata = {res.lost_segments, res.window};
   assign rsp_tuser = {res.timeout_seen, res.send_kind, res.retransmit_kind, res.in_recovery};

endmodule
